[design/cks_pkg.sv]
// Shared types, constants and the quarter-round helper for the ChaCha20 keystream generator.
`timescale 1ns / 1ps

package cks_pkg;

    // Number of double rounds per block.
    localparam int DOUBLE_ROUNDS = 10;
    // Each double round takes four half quarter-round steps.
    localparam int ROUND_STEPS = 4 * DOUBLE_ROUNDS;
    localparam int STEP_W = $clog2(ROUND_STEPS);

    // Words in one block and the width of a word index that can also hold "empty".
    localparam int BLOCK_WORDS = 16;
    localparam int INDEX_W = $clog2(BLOCK_WORDS) + 1;
    localparam int WORD_SEL_W = $clog2(BLOCK_WORDS);
    localparam int COUNTER_WORD = 12;

    // Configuration register file.
    localparam int SEED_REGS = 8;
    localparam int SEED_SEL_W = $clog2(SEED_REGS);
    localparam int PADDR_W = SEED_SEL_W + 3;

    // Request queue between the front and the back end.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef logic [31:0] word_t;
    typedef logic [BLOCK_WORDS-1:0][31:0] block_t;
    typedef logic [SEED_REGS-1:0][63:0] seed_t;

    // Four words taken by one quarter round.
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    // Block engine request and status.
    typedef struct packed {
        logic   start;
        block_t init;
    } core_req_t;

    typedef struct packed {
        logic idle;
    } core_status_t;

    // Head of the request queue as seen by the back end.
    typedef struct packed {
        logic empty;
        logic restart;
    } fifo_head_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN,
        CORE_FINAL
    } core_state_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_WAIT
    } back_state_t;

    // One half of a quarter round: rotations 16/12 in the first half, 8/7 in the second.
    function automatic quad_t qr_half(quad_t q, logic second);
        quad_t r;
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        a = q.a + q.b;
        d = q.d ^ a;
        d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
        c = q.c + d;
        b = q.b ^ c;
        b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        return r;
    endfunction

endpackage

[design/cks_fifo.sv]
// Short request queue that decouples the accepting front end from the keystream back end.
`timescale 1ns / 1ps

module cks_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic                push_restart,
    output logic                full,
    input  logic                pop,
    output cks_pkg::fifo_head_t head
);

    logic [cks_pkg::FIFO_DEPTH-1:0] mem_reg;
    logic [cks_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [cks_pkg::FIFO_PTR_W-1:0] wr_ptr_next;
    logic [cks_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [cks_pkg::FIFO_PTR_W-1:0] rd_ptr_next;
    logic [cks_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [cks_pkg::FIFO_CNT_W-1:0] count_next;

    // Status toward both sides.
    assign full         = (count_reg == cks_pkg::FIFO_CNT_W'(cks_pkg::FIFO_DEPTH));
    assign head.empty   = (count_reg == '0);
    assign head.restart = mem_reg[rd_ptr_reg];

    // Pointer and occupancy updates.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_restart;
        end
    end

endmodule

[design/cks_core.sv]
// ChaCha20 block engine: four parallel half quarter rounds per cycle, then the feed-forward add.
`timescale 1ns / 1ps

module cks_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cks_pkg::core_req_t    req,
    output cks_pkg::core_status_t status,
    output cks_pkg::block_t       block
);

    cks_pkg::core_state_t       state_reg;
    cks_pkg::core_state_t       state_next;
    logic [cks_pkg::STEP_W-1:0] step_reg;
    logic [cks_pkg::STEP_W-1:0] step_next;
    cks_pkg::block_t            init_reg;
    cks_pkg::block_t            work_reg;
    cks_pkg::block_t            work_next;
    cks_pkg::block_t            block_reg;
    cks_pkg::block_t            sum;
    logic                       last_step;
    logic                       load;

    assign last_step = (step_reg == cks_pkg::STEP_W'(cks_pkg::ROUND_STEPS - 1));
    assign block     = block_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cks_pkg::CORE_IDLE: begin
                if (req.start) begin
                    state_next = cks_pkg::CORE_RUN;
                end
            end
            cks_pkg::CORE_RUN: begin
                if (last_step) begin
                    state_next = cks_pkg::CORE_FINAL;
                end
            end
            cks_pkg::CORE_FINAL: begin
                state_next = cks_pkg::CORE_IDLE;
            end
            default: begin
                state_next = cks_pkg::CORE_IDLE;
            end
        endcase
    end

    // Outputs and step counter control.
    always_comb begin
        status.idle = 1'b0;
        load        = 1'b0;
        step_next   = step_reg;
        case (state_reg)
            cks_pkg::CORE_IDLE: begin
                status.idle = 1'b1;
                load        = req.start;
                step_next   = '0;
            end
            cks_pkg::CORE_RUN: begin
                step_next = step_reg + 1'b1;
            end
            cks_pkg::CORE_FINAL: begin
                step_next = '0;
            end
            default: begin
                step_next = '0;
            end
        endcase
    end

    // One step: column or diagonal round, first or second half, on all four lanes.
    always_comb begin
        cks_pkg::quad_t               q;
        cks_pkg::quad_t               r;
        logic [1:0]                   lane;
        logic [1:0]                   ib;
        logic [1:0]                   ic;
        logic [1:0]                   id;
        logic [cks_pkg::WORD_SEL_W-1:0] xa;
        logic [cks_pkg::WORD_SEL_W-1:0] xb;
        logic [cks_pkg::WORD_SEL_W-1:0] xc;
        logic [cks_pkg::WORD_SEL_W-1:0] xd;
        work_next = work_reg;
        for (int i = 0; i < 4; i++) begin
            lane = 2'(i);
            ib   = step_reg[1] ? lane + 2'd1 : lane;
            ic   = step_reg[1] ? lane + 2'd2 : lane;
            id   = step_reg[1] ? lane + 2'd3 : lane;
            xa   = {2'b00, lane};
            xb   = {2'b01, ib};
            xc   = {2'b10, ic};
            xd   = {2'b11, id};
            q.a  = work_reg[xa];
            q.b  = work_reg[xb];
            q.c  = work_reg[xc];
            q.d  = work_reg[xd];
            r    = cks_pkg::qr_half(q, step_reg[0]);
            work_next[xa] = r.a;
            work_next[xb] = r.b;
            work_next[xc] = r.c;
            work_next[xd] = r.d;
        end
    end

    // Feed-forward addition of the input state.
    always_comb begin
        for (int i = 0; i < cks_pkg::BLOCK_WORDS; i++) begin
            sum[i] = work_reg[i] + init_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cks_pkg::CORE_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Working state, saved input state and finished block.
    always_ff @(posedge aclk) begin
        if (load) begin
            init_reg <= req.init;
            work_reg <= req.init;
        end else if (state_reg == cks_pkg::CORE_RUN) begin
            work_reg <= work_next;
        end
        if (state_reg == cks_pkg::CORE_FINAL) begin
            block_reg <= sum;
        end
    end

endmodule

[design/cks_back.sv]
// Back end: tracks the word index and counter offset, starts refills and fills the output register.
`timescale 1ns / 1ps

module cks_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cks_pkg::seed_t        seed,
    input  cks_pkg::fifo_head_t   head,
    output logic                  pop,
    output cks_pkg::core_req_t    core_req,
    input  cks_pkg::core_status_t core_status,
    input  cks_pkg::block_t       block,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata
);

    cks_pkg::back_state_t        state_reg;
    cks_pkg::back_state_t        state_next;
    logic [cks_pkg::INDEX_W-1:0] index_reg;
    logic [cks_pkg::INDEX_W-1:0] index_next;
    logic [cks_pkg::INDEX_W-1:0] index_eff;
    cks_pkg::word_t              offset_reg;
    cks_pkg::word_t              offset_next;
    cks_pkg::word_t              offset_eff;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    cks_pkg::word_t              out_data_reg;
    cks_pkg::word_t              out_data_next;
    logic                        out_free;
    logic                        need_refill;
    logic                        load_out;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_free = !out_valid_reg || m_tready;

    // A restart empties the buffer and sets the offset back so the next refill uses offset 0.
    assign index_eff   = head.restart ? cks_pkg::INDEX_W'(cks_pkg::BLOCK_WORDS) : index_reg;
    assign offset_eff  = head.restart ? '1 : offset_reg;
    assign need_refill = index_eff[cks_pkg::INDEX_W-1];

    // Input state for a refill, with the counter word advanced by the new offset.
    always_comb begin
        for (int i = 0; i < cks_pkg::BLOCK_WORDS; i++) begin
            core_req.init[i] = seed[i / 2][(i % 2) * 32 +: 32];
        end
        core_req.init[cks_pkg::COUNTER_WORD] =
            seed[cks_pkg::COUNTER_WORD / 2][31:0] + offset_eff + 32'd1;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cks_pkg::BACK_IDLE: begin
                if (!head.empty && out_free && need_refill) begin
                    state_next = cks_pkg::BACK_WAIT;
                end
            end
            cks_pkg::BACK_WAIT: begin
                if (core_status.idle && out_free) begin
                    state_next = cks_pkg::BACK_IDLE;
                end
            end
            default: begin
                state_next = cks_pkg::BACK_IDLE;
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb begin
        pop            = 1'b0;
        core_req.start = 1'b0;
        load_out       = 1'b0;
        index_next     = index_reg;
        offset_next    = offset_reg;
        out_data_next  = out_data_reg;
        case (state_reg)
            cks_pkg::BACK_IDLE: begin
                if (!head.empty && out_free) begin
                    pop = 1'b1;
                    if (need_refill) begin
                        core_req.start = 1'b1;
                        offset_next    = offset_eff + 32'd1;
                        index_next     = index_eff;
                    end else begin
                        load_out      = 1'b1;
                        out_data_next = block[index_eff[cks_pkg::WORD_SEL_W-1:0]];
                        index_next    = index_eff + 1'b1;
                    end
                end
            end
            cks_pkg::BACK_WAIT: begin
                if (core_status.idle && out_free) begin
                    load_out      = 1'b1;
                    out_data_next = block[0];
                    index_next    = cks_pkg::INDEX_W'(1);
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cks_pkg::BACK_IDLE;
            index_reg     <= cks_pkg::INDEX_W'(cks_pkg::BLOCK_WORDS);
            offset_reg    <= '1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            index_reg     <= index_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register.
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

[design/chacha20_keystream_generator.sv]
// Top level of the ChaCha20 keystream generator: configuration registers, front end and wiring.
//
// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       s_tdata[0] restart
// m_        out        m_tvalid / m_tready       m_tdata[31:0] key_word
// APB       in         psel & penable & pwrite   paddr[5:3] register, pwdata seed words
//
// A word from the current block passes from the request queue into the output word register.
// A refill runs the block engine through its 40 steps and the feed-forward add, and each
// refill serves 16 words to a stream of requests.
// Reset empties the block buffer and the request queue and zeroes the seed registers.
// The four-entry queue keeps taking requests while the output register is stalled, until it is full.
`timescale 1ns / 1ps

module chacha20_keystream_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Request channel; s_tdata: [0] restart, [7:1] zero.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    // Keystream channel; m_tdata: [31:0] key_word.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cks_pkg::PADDR_W-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    cks_pkg::seed_t                 seed_reg;
    logic [cks_pkg::SEED_SEL_W-1:0] reg_sel;
    logic                           fifo_full;
    logic                           fifo_pop;
    cks_pkg::fifo_head_t            fifo_head;
    cks_pkg::core_req_t             core_req;
    cks_pkg::core_status_t          core_status;
    cks_pkg::block_t                core_block;

    // Register file access; each register sits on an 8-byte boundary.
    assign reg_sel = paddr[cks_pkg::PADDR_W-1:3];
    assign pready  = 1'b1;
    assign prdata  = seed_reg[reg_sel];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (psel && penable && pwrite) begin
            seed_reg[reg_sel] <= pwdata;
        end
    end

    // Front end: a request transfer is taken whenever the queue has room.
    assign s_tready = !fifo_full;

    cks_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (s_tvalid && !fifo_full),
        .push_restart (s_tdata[0]),
        .full         (fifo_full),
        .pop          (fifo_pop),
        .head         (fifo_head)
    );

    cks_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .seed        (seed_reg),
        .head        (fifo_head),
        .pop         (fifo_pop),
        .core_req    (core_req),
        .core_status (core_status),
        .block       (core_block),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    cks_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (core_req),
        .status  (core_status),
        .block   (core_block)
    );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the ChaCha20 keystream generator: stream stimulus, APB seeding and word checks.
`timescale 1ns / 1ps

import cks_pkg::*;

// Tracks the generator's block buffer and counter offset and holds the keystream words still due.
class keystream_scoreboard;
    logic [63:0] seed[SEED_REGS];
    word_t       block_words[BLOCK_WORDS];
    word_t       work[BLOCK_WORDS];
    int unsigned next_word;
    word_t       offset;
    word_t       expected_words[$];
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_restarts;
    int unsigned n_refills;
    int unsigned n_wraps;

    function new();
        foreach (seed[i]) seed[i] = '0;
        foreach (block_words[i]) block_words[i] = '0;
        next_word = BLOCK_WORDS;
        offset = '1;
    endfunction

    function void set_seed(int idx, logic [63:0] value);
        if (idx < SEED_REGS) seed[idx] = value;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    static function word_t rotl(word_t v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function void quarter(int a, int b, int c, int d);
        work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 16);
        work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 12);
        work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 8);
        work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 7);
    endfunction

    // Builds the input state with the running offset on word 12 and runs the full block function.
    function void refill();
        word_t       init_w[BLOCK_WORDS];
        logic [32:0] counter_sum;
        for (int i = 0; i < SEED_REGS; i++) begin
            init_w[2*i]   = seed[i][31:0];
            init_w[2*i+1] = seed[i][63:32];
        end
        counter_sum = {1'b0, init_w[COUNTER_WORD]} + {1'b0, offset};
        if (counter_sum[32]) n_wraps++;
        init_w[COUNTER_WORD] = counter_sum[31:0];
        work = init_w;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
        end
        for (int i = 0; i < BLOCK_WORDS; i++) block_words[i] = work[i] + init_w[i];
        n_refills++;
    endfunction

    // Called for every accepted request transfer.
    function void note_request(bit restart);
        if (restart) begin
            next_word = BLOCK_WORDS;
            offset = '1;
            n_restarts++;
        end
        if (next_word >= BLOCK_WORDS) begin
            offset += 1;
            refill();
            next_word = 0;
        end
        expected_words.push_back(block_words[next_word]);
        next_word++;
    endfunction

    // Called for every accepted keystream transfer.
    function void check_word(word_t got);
        word_t want;
        if (expected_words.size() == 0) begin
            $error("key_word with no request outstanding: expected none, actual %h", got);
            n_errors++;
            return;
        end
        want = expected_words.pop_front();
        n_checked++;
        if (got !== want) begin
            $error("key_word mismatch: expected %h, actual %h", want, got);
            n_errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int CLK_HALF_NS  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_PCT     = 6;
    // Settling time at the end of the test for any word still in flight.
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 800000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [31:0]        m_tdata;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    bit                  quiet_stretch = 1'b0;
    int unsigned         cycle_count = 0;
    int unsigned         requests_sent = 0;
    int unsigned         seed_writes = 0;
    keystream_scoreboard sb = new();

    chacha20_keystream_generator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    // Random back-pressure on the keystream channel.
    always @(negedge aclk) begin
        m_tready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Every keystream transfer is checked against the oldest expected word.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Two-phase APB write of one seed register.
    task automatic write_seed(input int idx, input logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(8 * idx);
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_seed(idx, value);
        seed_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one request, with an occasional idle cycle first, and waits for its transfer.
    task automatic send_request(input bit restart);
        @(negedge aclk);
        while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(restart);
        requests_sent++;
    endtask

    // Stops requests and waits until every expected word has come out.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Seed values: mostly random, some all zeros or all ones, and counters close to wrapping.
    function automatic logic [63:0] pick_seed(int idx);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (roll < 16) return '1;
        if (idx == COUNTER_WORD / 2 && roll < 40)
            return {$urandom, 32'hFFFF_FFFF - $urandom_range(0, 2)};
        return {$urandom, $urandom};
    endfunction

    initial begin
        int unsigned phase_no;
        int unsigned random_start;
        int          phase_len;
        int          restart_pct;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset seeds: restart on the empty buffer, plain words, and a restart mid-block.
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        // All-ones seeds: a full block with counter 0xFFFFFFFF, then the wrap to zero.
        for (int r = 0; r < SEED_REGS; r++) write_seed(r, '1);
        send_request(1'b1);
        repeat (16) send_request(1'b0);
        drain();

        // Random phases; seeds change between phases, often with a block half used.
        phase_no = 0;
        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_ITEMS) begin
            for (int r = 0; r < SEED_REGS; r++) begin
                if (phase_no == 0 || $urandom_range(0, 99) < 40) write_seed(r, pick_seed(r));
            end
            case ($urandom_range(0, 2))
                0:       restart_pct = 0;
                1:       restart_pct = 3;
                default: restart_pct = 25;
            endcase
            phase_len = $urandom_range(20, 180);
            if (phase_no == 3) begin
                quiet_stretch = 1'b1;
                phase_len = 320;
                restart_pct = 2;
            end
            send_request($urandom_range(0, 1) == 1);
            for (int i = 1; i < phase_len; i++)
                send_request($urandom_range(0, 99) < restart_pct);
            drain();
            quiet_stretch = 1'b0;
            phase_no++;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d keystream words from %0d requests over %0d block computations.",
                 sb.n_checked, requests_sent, sb.n_refills);
        $display("Saw %0d restarts, %0d block counter wraps and %0d seed register writes.",
                 sb.n_restarts, sb.n_wraps, seed_writes);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
